[rtl/mrr_pkg.sv]
`timescale 1ns / 1ps
// mrr_pkg: shared widths and sequencer states for the Miller-Rabin round block.
// No dependencies.
package mrr_pkg;
  localparam int NumBits = 63;
  localparam int CntW = $clog2(NumBits + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_SPLIT,
    ST_POW_MUL,
    ST_POW_SQR,
    ST_POW_NEXT,
    ST_CHECK,
    ST_SQR,
    ST_SQR_CHECK,
    ST_DONE
  } state_t;
endpackage

[rtl/miller_rabin_round_top.sv]
`timescale 1ns / 1ps
// miller_rabin_round_top: one Miller-Rabin round on a 63-bit candidate and witness.
// A round takes up to 2*(bits of m)+s-2 modular multiplies plus a witness reduction.
// Throughput: one item at a time; busy stays high from transfer to result strobe.
// Reset (rst, synchronous, active high) returns the sequencer to idle; no result pending.
// The receiver cannot stall: done pulses one cycle with probably_prime.
module miller_rabin_round_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [mrr_pkg::NumBits-1:0]   candidate,
  input  logic [mrr_pkg::NumBits-1:0]   witness,
  output logic                          done,
  output logic                          probably_prime
);
  localparam int W = mrr_pkg::NumBits;

  mrr_pkg::state_t state, state_next;

  logic [W-1:0] n;         // candidate
  logic [W-1:0] nm1;       // n-1
  logic [W-1:0] base;      // running square of the witness
  logic [W-1:0] f;         // accumulator / test value
  logic [W-1:0] expo;      // remaining exponent bits (shifted right)
  logic [W-1:0] rem;       // witness reduction remainder
  logic [W-1:0] wq;        // witness bits being shifted in
  logic [mrr_pkg::CntW-1:0] twos;
  logic [mrr_pkg::CntW-1:0] cnt;
  logic         verdict;

  // shared multiplier
  logic         mm_go;
  logic [W-1:0] mm_x, mm_y;
  logic         mm_done;
  logic [W-1:0] mm_res;

  mrr_modmul u_mul (
    .clk(clk), .rst(rst), .go(mm_go), .x(mm_x), .y(mm_y), .n(n),
    .done(mm_done), .result(mm_res)
  );

  logic         started;   // multiply launched in current state
  logic [W:0]   rem_sh;

  assign busy = (state != mrr_pkg::ST_IDLE);
  assign rem_sh = {rem, wq[W-1]};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mrr_pkg::ST_IDLE:
        if (start) state_next = mrr_pkg::ST_REDUCE;
      mrr_pkg::ST_REDUCE:
        // restoring remainder, one witness bit per cycle
        if (cnt == mrr_pkg::CntW'(1)) state_next = mrr_pkg::ST_SPLIT;
      mrr_pkg::ST_SPLIT:
        if (n < W'(2) || n == W'(2)) state_next = mrr_pkg::ST_DONE;
        else if (expo[0]) state_next = mrr_pkg::ST_POW_MUL;
      mrr_pkg::ST_POW_MUL:
        if (!expo[0] || mm_done) state_next = mrr_pkg::ST_POW_SQR;
      mrr_pkg::ST_POW_SQR:
        if (expo == W'(1)) state_next = mrr_pkg::ST_CHECK;
        else if (mm_done) state_next = mrr_pkg::ST_POW_NEXT;
      mrr_pkg::ST_POW_NEXT:
        state_next = mrr_pkg::ST_POW_MUL;
      mrr_pkg::ST_CHECK:
        if (f == W'(1) || f == nm1 || cnt <= mrr_pkg::CntW'(1))
          state_next = mrr_pkg::ST_DONE;
        else state_next = mrr_pkg::ST_SQR;
      mrr_pkg::ST_SQR:
        if (mm_done) state_next = mrr_pkg::ST_SQR_CHECK;
      mrr_pkg::ST_SQR_CHECK:
        if (f == W'(1) || f == nm1 || cnt <= mrr_pkg::CntW'(1))
          state_next = mrr_pkg::ST_DONE;
        else state_next = mrr_pkg::ST_SQR;
      mrr_pkg::ST_DONE:
        state_next = mrr_pkg::ST_IDLE;
      default:
        state_next = mrr_pkg::ST_IDLE;
    endcase
  end

  // multiplier launch control
  always_comb begin
    mm_go = 1'b0;
    mm_x = f;
    mm_y = base;
    case (state)
      mrr_pkg::ST_POW_MUL: begin
        mm_go = expo[0] && !started;
      end
      mrr_pkg::ST_POW_SQR: begin
        mm_go = !started && (expo != W'(1));
        mm_x = base;
      end
      mrr_pkg::ST_SQR: begin
        mm_go = !started;
        mm_y = f;
      end
      default: begin
        mm_go = 1'b0;
      end
    endcase
  end

  assign done = (state == mrr_pkg::ST_DONE);
  assign probably_prime = verdict;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrr_pkg::ST_IDLE;
      started <= 1'b0;
    end else begin
      state <= state_next;
      if (state_next != state) started <= 1'b0;
      else if (mm_go) started <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      mrr_pkg::ST_IDLE: begin
        n <= candidate;
        nm1 <= candidate - W'(1);
        expo <= candidate - W'(1);
        wq <= witness;
        rem <= '0;
        twos <= '0;
        f <= W'(1);
        cnt <= mrr_pkg::CntW'(W);
        verdict <= 1'b0;
      end
      mrr_pkg::ST_REDUCE: begin
        rem <= (rem_sh >= {1'b0, n}) ? W'(rem_sh - {1'b0, n}) : rem_sh[W-1:0];
        wq <= {wq[W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
      end
      mrr_pkg::ST_SPLIT: begin
        base <= rem;
        if (n < W'(2)) verdict <= 1'b0;
        else if (n == W'(2)) verdict <= 1'b1;
        else if (!expo[0]) begin
          expo <= {1'b0, expo[W-1:1]};
          twos <= twos + 1'b1;
        end
      end
      mrr_pkg::ST_POW_MUL: begin
        if (mm_done) f <= mm_res;
      end
      mrr_pkg::ST_POW_SQR: begin
        if (mm_done) base <= mm_res;
        cnt <= twos;
      end
      mrr_pkg::ST_POW_NEXT: begin
        expo <= {1'b0, expo[W-1:1]};
      end
      mrr_pkg::ST_CHECK, mrr_pkg::ST_SQR_CHECK: begin
        if (state == mrr_pkg::ST_SQR_CHECK && f == W'(1)) verdict <= 1'b0;
        else verdict <= (f == W'(1) && state == mrr_pkg::ST_CHECK) || f == nm1;
        cnt <= cnt - 1'b1;
      end
      mrr_pkg::ST_SQR: begin
        if (mm_done) f <= mm_res;
      end
      default: begin
        verdict <= verdict;
      end
    endcase
  end
endmodule

[rtl/mrr_modmul.sv]
`timescale 1ns / 1ps
// mrr_modmul: iterative (x*y) mod n, one multiplier bit per cycle, doubling and adding.
// Depends on mrr_pkg.
module mrr_modmul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [mrr_pkg::NumBits-1:0]   x,
  input  logic [mrr_pkg::NumBits-1:0]   y,
  input  logic [mrr_pkg::NumBits-1:0]   n,
  output logic                          done,
  output logic [mrr_pkg::NumBits-1:0]   result
);
  logic                        running;
  logic [mrr_pkg::CntW-1:0]    bit_cnt;
  logic [mrr_pkg::NumBits-1:0] xr;
  logic [mrr_pkg::NumBits-1:0] yr;
  logic [mrr_pkg::NumBits:0]   dbl;
  logic [mrr_pkg::NumBits:0]   red1;
  logic [mrr_pkg::NumBits:0]   add;
  logic [mrr_pkg::NumBits:0]   acc_next;

  // acc < n, so 2*acc and acc+x fit in NumBits+1 bits; one subtract each.
  always_comb begin
    dbl = {result, 1'b0};
    red1 = (dbl >= {1'b0, n}) ? dbl - {1'b0, n} : dbl;
    add = red1 + {1'b0, xr};
    if (yr[mrr_pkg::NumBits-1]) begin
      acc_next = (add >= {1'b0, n}) ? add - {1'b0, n} : add;
    end else begin
      acc_next = red1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        bit_cnt <= mrr_pkg::CntW'(mrr_pkg::NumBits);
      end else if (running) begin
        bit_cnt <= bit_cnt - 1'b1;
        if (bit_cnt == mrr_pkg::CntW'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      result <= '0;
      xr <= x;
      yr <= y;
    end else if (running) begin
      result <= acc_next[mrr_pkg::NumBits-1:0];
      yr <= {yr[mrr_pkg::NumBits-2:0], 1'b0};
    end
  end
endmodule
